[src/mslc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mslc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 3;
    localparam logic [31:0] MEAS_RESET = 32'd20000;

    typedef enum logic [2:0] {
        CFG_FILTER_KEEP  = 3'd0,
        CFG_SPEED_SCALE  = 3'd1,
        CFG_LOOP_GAIN    = 3'd2,
        CFG_ZERO_SUM     = 3'd3,
        CFG_ZERO_PRODUCT = 3'd4,
        CFG_POLE_SUM     = 3'd5,
        CFG_POLE_PRODUCT = 3'd6,
        CFG_MEAS_IVL     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] target_speed;
        logic        [15:0] pulse_count;
        logic        [31:0] since_measure_us;
        logic        [31:0] since_step_us;
    } t_in;

    typedef struct packed {
        logic        [7:0]  pwm_duty;
        logic               clear_count;
        logic signed [15:0] measured_speed;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,      // rate division, one quotient bit per cycle
        S_DT,       // dt by reciprocal multiply
        S_M_KEEP,   // filter_keep * filtered_speed
        S_M_SCALE,  // speed_scale * rate
        S_ERR,
        S_M_GAIN,
        S_M_XDT,
        S_M_IIDT,
        S_M_ZS,
        S_M_ZP,
        S_M_PS,
        S_M_PP,
        S_Y,
        S_M_YDT,
        S_M_OIDT,
        S_OUT
    } t_state;

    // Multiplier unit control
    typedef struct packed {
        logic               start;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_mul_req;

endpackage
`default_nettype wire

[src/motor_speed_lead_lag_control.sv]
`timescale 1ns / 1ps
`default_nettype none
// Motor speed lead/lag controller.
// Input channel (i_in_valid/o_in_ready, t_in): one control step per
// transaction: target speed, encoder pulses, us since last measurement,
// us since last step. Output channel (o_out_valid/i_out_ready, t_out):
// one result per step: PWM duty 0..255, clear-count flag, measured speed.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx,
// allowed only while idle.
// From accept to o_out_valid: dt is a reciprocal multiply; with a
// measurement, the pulse rate takes the 64-step bit-serial divider plus
// its done flop. The shared two-stage multiplier makes nine passes per
// step, two more with a measurement. A new step is taken only once the
// current one is finished and the sequencer is idle again.
// o_in_ready is high whenever the sequencer is idle. A finished result
// waits in the output register while the next step is computed; if it is
// still unclaimed when the next one is done, the sequencer holds and no
// new step is taken.
// Reset clears all integrators and filtered speed, config to defaults
// (measurement interval 20000 us, all others zero).
module motor_speed_lead_lag_control #(
    parameter int FRAC_BITS = mslc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire mslc_pkg::t_in                     i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output mslc_pkg::t_out                         o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [mslc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [31:0]                       i_cfg_data
);
    import mslc_pkg::*;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] MAX32 = 64'sh7FFFFFFF;
    localparam logic signed [63:0] MIN32 = -64'sh80000000;
    // dt = floor(us * 2^F / 1e6) as (us * ceil(2^(30+F) / 1e6)) >> 30,
    // exact for us up to 50000
    localparam int DT_SHIFT = 30;
    localparam logic [63:0] DT_MUL =
        ((64'd1 << (DT_SHIFT + FRAC_BITS)) + 64'd999999) / 64'd1000000;

    // configuration
    logic signed [31:0] r_keep, r_scale, r_gain, r_zs, r_zp, r_ps, r_pp;
    logic        [31:0] r_ivl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= '0; r_scale <= '0; r_gain <= '0; r_zs <= '0;
            r_zp <= '0; r_ps <= '0; r_pp <= '0; r_ivl <= MEAS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FILTER_KEEP:  r_keep  <= i_cfg_data;
                CFG_SPEED_SCALE:  r_scale <= i_cfg_data;
                CFG_LOOP_GAIN:    r_gain  <= i_cfg_data;
                CFG_ZERO_SUM:     r_zs    <= i_cfg_data;
                CFG_ZERO_PRODUCT: r_zp    <= i_cfg_data;
                CFG_POLE_SUM:     r_ps    <= i_cfg_data;
                CFG_POLE_PRODUCT: r_pp    <= i_cfg_data;
                CFG_MEAS_IVL:     r_ivl   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state
    t_state r_state, n_state;
    logic signed [31:0] r_fs, n_fs, r_ii, n_ii, r_iii, n_iii;
    logic signed [31:0] r_oi, n_oi, r_ooi, n_ooi;
    t_in    r_in, n_in;
    logic   r_meas, n_meas;
    logic   r_clr, n_clr;
    logic signed [31:0] r_rq, n_rq, r_dt, n_dt, r_x, n_x, r_e, n_e, r_y, n_y;
    logic signed [63:0] r_acc, n_acc;
    logic [1:0] r_ph, n_ph;        // multiplier phase
    logic   r_ov, n_ov;
    t_out   r_out, n_out;

    // shared units
    t_mul_req         s_mreq;
    logic signed [31:0] s_mq;
    logic signed [63:0] s_mshr;
    logic             s_dstart, s_ddone;
    logic [63:0]      s_dnum, s_dquo;
    logic [31:0]      s_dden;

    mslc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_req(s_mreq), .o_q(s_mq), .o_shr(s_mshr)
    );
    mslc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_dstart),
        .i_num(s_dnum), .i_den(s_dden), .o_done(s_ddone), .o_quo(s_dquo)
    );

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > MAX32) return 32'sh7FFFFFFF;
        if (v < MIN32) return -32'sh80000000;
        return v[31:0];
    endfunction

    logic signed [63:0] v_t;
    logic [63:0] v_pul;
    logic [15:0] v_ss;
    logic [63:0] v_dtp;

    always_comb begin
        n_state = r_state; n_fs = r_fs; n_ii = r_ii; n_iii = r_iii;
        n_oi = r_oi; n_ooi = r_ooi; n_in = r_in; n_meas = r_meas;
        n_clr = r_clr; n_rq = r_rq; n_dt = r_dt; n_x = r_x; n_e = r_e;
        n_y = r_y; n_acc = r_acc; n_ph = r_ph; n_ov = r_ov; n_out = r_out;
        s_mreq = '0; s_dstart = 1'b0; s_dnum = '0; s_dden = 32'd1;
        v_t = '0;
        v_ss = '0;
        v_dtp = '0;
        v_pul = 64'(r_in.pulse_count) * 64'd1000000;
        o_in_ready = (r_state == S_IDLE);
        if (r_ov && i_out_ready) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_in = i_in;
                    n_meas = (i_in.since_measure_us >= r_ivl);
                    n_clr = (i_in.since_step_us > 32'd50000);
                    n_state = S_DT;
                end
            end
            S_DT: begin
                // overlong step runs as 5 ms
                v_ss = r_clr ? 16'd5000 : r_in.since_step_us[15:0];
                v_dtp = 64'(v_ss) * DT_MUL;
                n_dt = 32'(v_dtp >> DT_SHIFT);
                if (r_meas) begin
                    s_dstart = 1'b1;
                    s_dnum = v_pul << FRAC_BITS;
                    s_dden = (r_in.since_measure_us == '0) ? 32'd1 :
                             r_in.since_measure_us;
                    n_state = S_DIV;
                end else begin
                    n_state = S_ERR;
                end
            end
            S_DIV: begin
                if (s_ddone) begin
                    n_rq = (s_dquo > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : s_dquo[31:0];
                    n_ph = '0;
                    n_state = S_M_KEEP;
                end
            end
            S_M_KEEP: begin
                s_mreq.a = r_fs; s_mreq.b = r_keep;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_acc = s_mshr; n_ph = '0; n_state = S_M_SCALE;
                end
            end
            S_M_SCALE: begin
                s_mreq.a = r_rq; s_mreq.b = r_scale;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_fs = sat(r_acc + s_mshr); n_ph = '0; n_state = S_ERR;
                end
            end
            S_ERR: begin
                v_t = (64'(r_in.target_speed) <<< FRAC_BITS) - 64'(r_fs);
                n_e = sat(v_t);
                if (r_clr) begin
                    n_ii = '0; n_iii = '0; n_oi = '0; n_ooi = '0;
                end
                n_ph = '0;
                n_state = S_M_GAIN;
            end
            S_M_GAIN: begin
                s_mreq.a = r_gain; s_mreq.b = r_e;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_x = s_mq; n_ph = '0; n_state = S_M_XDT;
                end
            end
            S_M_XDT: begin
                s_mreq.a = r_x; s_mreq.b = r_dt;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_ii = sat(64'(r_ii) + 64'(s_mq)); n_ph = '0;
                    n_state = S_M_IIDT;
                end
            end
            S_M_IIDT: begin
                s_mreq.a = r_ii; s_mreq.b = r_dt;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_iii = sat(64'(r_iii) + 64'(s_mq)); n_ph = '0;
                    n_acc = 64'(r_x);
                    n_state = S_M_ZS;
                end
            end
            S_M_ZS: begin
                s_mreq.a = r_zs; s_mreq.b = r_ii;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_acc = r_acc - 64'(s_mq); n_ph = '0; n_state = S_M_ZP;
                end
            end
            S_M_ZP: begin
                s_mreq.a = r_zp; s_mreq.b = r_iii;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_acc = r_acc + 64'(s_mq); n_ph = '0; n_state = S_M_PS;
                end
            end
            S_M_PS: begin
                s_mreq.a = r_ps; s_mreq.b = r_oi;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_acc = r_acc + 64'(s_mq); n_ph = '0; n_state = S_M_PP;
                end
            end
            S_M_PP: begin
                s_mreq.a = r_pp; s_mreq.b = r_ooi;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_acc = r_acc - 64'(s_mq); n_ph = '0; n_state = S_Y;
                end
            end
            S_Y: begin
                n_y = sat(r_acc);
                n_state = S_M_YDT;
            end
            S_M_YDT: begin
                s_mreq.a = r_y; s_mreq.b = r_dt;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_oi = sat(64'(r_oi) + 64'(s_mq)); n_ph = '0;
                    n_state = S_M_OIDT;
                end
            end
            S_M_OIDT: begin
                s_mreq.a = r_oi; s_mreq.b = r_dt;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_ooi = sat(64'(r_ooi) + 64'(s_mq)); n_ph = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free or being drained
                if (!r_ov || i_out_ready) begin
                    // duty: clamp then integer part
                    if (r_y <= 0) n_out.pwm_duty = '0;
                    else if (64'(r_y) >= 64'sd255 * ONE) n_out.pwm_duty = 8'd255;
                    else n_out.pwm_duty = 8'(r_y >>> FRAC_BITS);
                    n_out.clear_count = r_meas;
                    v_t = 64'(r_fs) >>> FRAC_BITS;
                    if (v_t > 64'sd32767) n_out.measured_speed = 16'sh7FFF;
                    else if (v_t < -64'sd32768) n_out.measured_speed = -16'sh8000;
                    else n_out.measured_speed = v_t[15:0];
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fs <= '0; r_ii <= '0; r_iii <= '0; r_oi <= '0; r_ooi <= '0;
            r_ov <= 1'b0;
            r_ph <= '0;
        end else begin
            r_state <= n_state;
            r_fs <= n_fs; r_ii <= n_ii; r_iii <= n_iii;
            r_oi <= n_oi; r_ooi <= n_ooi;
            r_ov <= n_ov;
            r_ph <= n_ph;
        end
        r_in <= n_in; r_meas <= n_meas; r_clr <= n_clr; r_rq <= n_rq;
        r_dt <= n_dt; r_x <= n_x; r_e <= n_e; r_y <= n_y; r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out = r_out;
endmodule
`default_nettype wire

[src/mslc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared Q multiplier: registered operands, registered 64-bit product,
// then floor shift and saturation.
module mslc_mul #(
    parameter int FRAC_BITS = mslc_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire mslc_pkg::t_mul_req i_req,
    output logic signed [31:0]      o_q,      // sat(floor(a*b >> F))
    output logic signed [63:0]      o_shr     // floor(a*b >> F), unsaturated
);
    import mslc_pkg::*;

    logic signed [31:0] r_a, r_b;
    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_a <= i_req.a;
        r_b <= i_req.b;
        r_p <= r_a * r_b;
    end

    assign o_shr = r_p >>> FRAC_BITS;

    always_comb begin
        if (o_shr > 64'sh7FFFFFFF) o_q = 32'sh7FFFFFFF;
        else if (o_shr < -64'sh80000000) o_q = -32'sh80000000;
        else o_q = o_shr[31:0];
    end
endmodule
`default_nettype wire

[src/mslc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Done is registered: the quotient is complete when it is high.
module mslc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quo
);
    import mslc_pkg::*;

    logic [63:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done;
    logic [32:0] v_sh;

    always_comb begin
        n_quo = r_quo; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy;
        v_sh = {r_rem[31:0], r_quo[63]};
        if (i_start) begin
            n_quo = i_num; n_rem = '0; n_cnt = 7'd64; n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[62:0], 1'b0};
            if (v_sh >= {1'b0, r_den}) begin
                n_rem = v_sh - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end else begin
                n_rem = v_sh;
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= r_busy && (r_cnt == 7'd1) && !i_start;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire
